[design/imuspi_pkg.sv]
package imuspi_pkg;

  // event codes of the input transaction
  localparam logic [1:0] KIND_ACCEL_RDY = 2'd0;
  localparam logic [1:0] KIND_GYRO_RDY  = 2'd1;
  localparam logic [1:0] KIND_XFER_DONE = 2'd2;
  localparam logic [1:0] KIND_POLL      = 2'd3;

  // started source codes
  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_GYRO  = 2'd1;
  localparam logic [1:0] SRC_ACCEL = 2'd2;
  localparam logic [1:0] SRC_TEMP  = 2'd3;

  // burst lengths in bytes
  localparam logic [3:0] LEN_GYRO  = 4'd8;
  localparam logic [3:0] LEN_ACCEL = 4'd9;
  localparam logic [3:0] LEN_TEMP  = 4'd4;

  // burst command bytes
  localparam logic [7:0] CMD_GYRO  = 8'h82;
  localparam logic [7:0] CMD_ACCEL = 8'h92;
  localparam logic [7:0] CMD_TEMP  = 8'hA2;

  // flag bit positions
  localparam int FLAG_PEND   = 0;
  localparam int FLAG_FLIGHT = 1;
  localparam int FLAG_DONE   = 2;
  localparam int FLAG_NOTIFY = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic       bus_busy;
  } in_item_t;

  typedef struct packed {
    logic [1:0] start_source;
    logic [3:0] start_length;
    logic [7:0] start_command;
    logic       release_gyro_select;
    logic       release_accel_select;
    logic       raise_notify;
    logic       gyro_sample_taken;
    logic       accel_sample_taken;
    logic       temp_sample_taken;
  } out_item_t;

endpackage

[design/imuspi_core.sv]
module imuspi_core import imuspi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  logic      start_enable,
  output out_item_t res
);

  typedef struct packed {
    logic [3:0] gyro;
    logic [2:0] accel;
    logic [2:0] temp;
    logic [1:0] src;
  } sched_t;

  logic [3:0] gyro_r,  gyro_nxt;
  logic [2:0] accel_r, accel_nxt;
  logic [2:0] temp_r,  temp_nxt;
  sched_t     sch;

  // fixed priority start, only on an idle bus with no other source in flight
  function automatic sched_t try_start(input logic busy, input logic [3:0] g,
                                       input logic [2:0] a, input logic [2:0] t);
    sched_t s;
    s.gyro  = g;
    s.accel = a;
    s.temp  = t;
    s.src   = SRC_NONE;
    if (!busy) begin
      if (g[FLAG_PEND] && !a[FLAG_FLIGHT] && !t[FLAG_FLIGHT]) begin
        s.gyro[FLAG_PEND]   = 1'b0;
        s.gyro[FLAG_FLIGHT] = 1'b1;
        s.src = SRC_GYRO;
      end else if (a[FLAG_PEND] && !g[FLAG_FLIGHT] && !t[FLAG_FLIGHT]) begin
        s.accel[FLAG_PEND]   = 1'b0;
        s.accel[FLAG_FLIGHT] = 1'b1;
        s.src = SRC_ACCEL;
      end else if (t[FLAG_PEND] && !g[FLAG_FLIGHT] && !a[FLAG_FLIGHT]) begin
        s.temp[FLAG_PEND]   = 1'b0;
        s.temp[FLAG_FLIGHT] = 1'b1;
        s.src = SRC_TEMP;
      end
    end
    return s;
  endfunction

  function automatic logic [3:0] len_of(input logic [1:0] src);
    logic [3:0] l;
    case (src)
      SRC_GYRO:  l = LEN_GYRO;
      SRC_ACCEL: l = LEN_ACCEL;
      SRC_TEMP:  l = LEN_TEMP;
      default:   l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] cmd_of(input logic [1:0] src);
    logic [7:0] c;
    case (src)
      SRC_GYRO:  c = CMD_GYRO;
      SRC_ACCEL: c = CMD_ACCEL;
      SRC_TEMP:  c = CMD_TEMP;
      default:   c = 8'd0;
    endcase
    return c;
  endfunction

  always_comb begin
    gyro_nxt  = gyro_r;
    accel_nxt = accel_r;
    temp_nxt  = temp_r;
    sch       = '0;
    res       = '0;
    case (item.kind)
      KIND_ACCEL_RDY: begin
        accel_nxt[FLAG_PEND] = 1'b1;
        temp_nxt[FLAG_PEND]  = 1'b1;
        if (start_enable) begin
          sch = try_start(item.bus_busy, gyro_nxt, accel_nxt, temp_nxt);
          gyro_nxt  = sch.gyro;
          accel_nxt = sch.accel;
          temp_nxt  = sch.temp;
          res.start_source = sch.src;
        end
      end
      KIND_GYRO_RDY: begin
        gyro_nxt[FLAG_PEND] = 1'b1;
        if (start_enable) begin
          sch = try_start(item.bus_busy, gyro_nxt, accel_nxt, temp_nxt);
          gyro_nxt  = sch.gyro;
          accel_nxt = sch.accel;
          temp_nxt  = sch.temp;
          res.start_source = sch.src;
        end
      end
      KIND_XFER_DONE: begin
        if (gyro_nxt[FLAG_FLIGHT]) begin
          gyro_nxt[FLAG_FLIGHT] = 1'b0;
          gyro_nxt[FLAG_DONE]   = 1'b1;
          res.release_gyro_select = 1'b1;
        end
        if (accel_nxt[FLAG_FLIGHT]) begin
          accel_nxt[FLAG_FLIGHT] = 1'b0;
          accel_nxt[FLAG_DONE]   = 1'b1;
          res.release_accel_select = 1'b1;
        end
        if (temp_nxt[FLAG_FLIGHT]) begin
          temp_nxt[FLAG_FLIGHT] = 1'b0;
          temp_nxt[FLAG_DONE]   = 1'b1;
          res.release_accel_select = 1'b1;
        end
        // completion reschedules regardless of the enable
        sch = try_start(item.bus_busy, gyro_nxt, accel_nxt, temp_nxt);
        gyro_nxt  = sch.gyro;
        accel_nxt = sch.accel;
        temp_nxt  = sch.temp;
        res.start_source = sch.src;
        if (gyro_nxt[FLAG_DONE]) begin
          gyro_nxt[FLAG_DONE]   = 1'b0;
          gyro_nxt[FLAG_NOTIFY] = 1'b1;
          res.raise_notify = 1'b1;
        end
      end
      default: begin
        if (gyro_nxt[FLAG_NOTIFY]) begin
          gyro_nxt[FLAG_NOTIFY] = 1'b0;
          res.gyro_sample_taken = 1'b1;
        end
        if (accel_nxt[FLAG_DONE]) begin
          accel_nxt[FLAG_DONE] = 1'b0;
          res.accel_sample_taken = 1'b1;
        end
        if (temp_nxt[FLAG_DONE]) begin
          temp_nxt[FLAG_DONE] = 1'b0;
          res.temp_sample_taken = 1'b1;
        end
      end
    endcase
    res.start_length  = len_of(res.start_source);
    res.start_command = cmd_of(res.start_source);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_r  <= '0;
      accel_r <= '0;
      temp_r  <= '0;
    end else if (step_en) begin
      gyro_r  <= gyro_nxt;
      accel_r <= accel_nxt;
      temp_r  <= temp_nxt;
    end
  end

  a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({gyro_r[FLAG_FLIGHT], accel_r[FLAG_FLIGHT], temp_r[FLAG_FLIGHT]}) <= 1)
    else $error("more than one source in flight");

  a_gyro_start: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.start_source == SRC_GYRO |=> gyro_r[FLAG_FLIGHT] && !gyro_r[FLAG_PEND])
    else $error("gyro start did not mark gyro in flight");

  a_notify: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.raise_notify |=> gyro_r[FLAG_NOTIFY] && !gyro_r[FLAG_DONE])
    else $error("notify raised without notify flag");

  a_done_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.kind == KIND_XFER_DONE |=> !gyro_r[FLAG_DONE])
    else $error("gyro done left set after completion");

endmodule

[design/imu_spi_read_scheduler.sv]
// shared-bus burst read scheduler for gyro, accel and temperature sources
// input channel: in_valid / in_stall / in_data carries one event transaction
//   (accel ready, gyro ready, transfer complete, task poll) plus bus_busy
// result channel: out_valid / out_stall / out_data returns exactly one result
//   transaction per input transaction, in order
// config: cfg_write_en with cfg_write_data sets start_enable; write only while
//   the block holds no transaction
// latency: a transaction accepted at one edge is registered, processed by the
//   flag logic and lands in the result register at the next edge, so its result
//   is presented one cycle after acceptance and can be taken at the second edge
// throughput: one transaction per cycle; each event is a single update of the
//   flag registers plus a fixed priority pick, all in one cycle
// reset (rst_n low, synchronous): all flags and start_enable clear, both
//   registers empty
// stall: a stalled result holds in the output register; the input register
//   still drains into it when it is taken, and in_stall rises only when the
//   input register is full and cannot move on
module imu_spi_read_scheduler import imuspi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_write_en,
  input  logic      cfg_write_data
);

  logic      start_enable_r;
  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t res;
  logic      advance;

  // input stage moves on when the result register is empty or being taken
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_enable_r <= 1'b0;
    end else if (cfg_write_en) begin
      start_enable_r <= cfg_write_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_data_r <= in_data;
    end
  end

  // flag state and per-event logic
  imuspi_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .item         (in_data_r),
    .start_enable (start_enable_r),
    .res          (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

endmodule

[test/imu_spi_read_scheduler_test.sv]
module imu_spi_read_scheduler_test;
  import imuspi_pkg::*;

  // run guard, far above the slowest legal run of about a thousand transactions
  localparam int CYCLE_LIMIT = 200000;
  // quiet cycles after the last result
  localparam int DRAIN_CYCLES = 8;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_write_en;
  logic      cfg_write_data;

  // stimulus bookkeeping
  in_item_t  event_queue[$];
  out_item_t want_results[$];
  int        queued_count;
  int        accepted_count;
  int        cycle_count;
  int        errors;
  int        idle_pct;
  int        stall_pct;
  logic      last_in_fire;

  // scheduler state as the testbench sees it
  logic [3:0] gyro_st;
  logic [2:0] accel_st;
  logic [2:0] temp_st;
  logic       en_copy;

  imu_spi_read_scheduler u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // fixed priority pick: gyro, accel, temperature
  // a source only looks at the other two in-flight flags, never its own
  function automatic void launch_next(input logic busy, inout out_item_t r);
    if (busy) return;
    if (gyro_st[FLAG_PEND] && !accel_st[FLAG_FLIGHT] && !temp_st[FLAG_FLIGHT]) begin
      gyro_st[FLAG_PEND]   = 1'b0;
      gyro_st[FLAG_FLIGHT] = 1'b1;
      r.start_source  = SRC_GYRO;
      r.start_length  = LEN_GYRO;
      r.start_command = CMD_GYRO;
    end else if (accel_st[FLAG_PEND] && !gyro_st[FLAG_FLIGHT] && !temp_st[FLAG_FLIGHT]) begin
      accel_st[FLAG_PEND]   = 1'b0;
      accel_st[FLAG_FLIGHT] = 1'b1;
      r.start_source  = SRC_ACCEL;
      r.start_length  = LEN_ACCEL;
      r.start_command = CMD_ACCEL;
    end else if (temp_st[FLAG_PEND] && !gyro_st[FLAG_FLIGHT] && !accel_st[FLAG_FLIGHT]) begin
      temp_st[FLAG_PEND]   = 1'b0;
      temp_st[FLAG_FLIGHT] = 1'b1;
      r.start_source  = SRC_TEMP;
      r.start_length  = LEN_TEMP;
      r.start_command = CMD_TEMP;
    end
  endfunction

  // one event in, one result out, flag state advanced
  function automatic out_item_t next_schedule(input in_item_t ev);
    out_item_t r;
    r = '0;
    case (ev.kind)
      KIND_ACCEL_RDY: begin
        // accel ready also brings a temperature read
        accel_st[FLAG_PEND] = 1'b1;
        temp_st[FLAG_PEND]  = 1'b1;
        if (en_copy) launch_next(ev.bus_busy, r);
      end
      KIND_GYRO_RDY: begin
        gyro_st[FLAG_PEND] = 1'b1;
        if (en_copy) launch_next(ev.bus_busy, r);
      end
      KIND_XFER_DONE: begin
        if (gyro_st[FLAG_FLIGHT]) begin
          gyro_st[FLAG_FLIGHT] = 1'b0;
          gyro_st[FLAG_DONE]   = 1'b1;
          r.release_gyro_select = 1'b1;
        end
        if (accel_st[FLAG_FLIGHT]) begin
          accel_st[FLAG_FLIGHT] = 1'b0;
          accel_st[FLAG_DONE]   = 1'b1;
          r.release_accel_select = 1'b1;
        end
        if (temp_st[FLAG_FLIGHT]) begin
          temp_st[FLAG_FLIGHT] = 1'b0;
          temp_st[FLAG_DONE]   = 1'b1;
          r.release_accel_select = 1'b1;
        end
        // completion reschedules whatever start_enable holds
        launch_next(ev.bus_busy, r);
        if (gyro_st[FLAG_DONE]) begin
          gyro_st[FLAG_DONE]   = 1'b0;
          gyro_st[FLAG_NOTIFY] = 1'b1;
          r.raise_notify = 1'b1;
        end
      end
      default: begin
        if (gyro_st[FLAG_NOTIFY]) begin
          gyro_st[FLAG_NOTIFY] = 1'b0;
          r.gyro_sample_taken = 1'b1;
        end
        if (accel_st[FLAG_DONE]) begin
          accel_st[FLAG_DONE] = 1'b0;
          r.accel_sample_taken = 1'b1;
        end
        if (temp_st[FLAG_DONE]) begin
          temp_st[FLAG_DONE] = 1'b0;
          r.temp_sample_taken = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.start_source !== want.start_source)
      report_mismatch($sformatf("start_source got %0d want %0d",
                                got.start_source, want.start_source));
    if (got.start_length !== want.start_length)
      report_mismatch($sformatf("start_length got %0d want %0d",
                                got.start_length, want.start_length));
    if (got.start_command !== want.start_command)
      report_mismatch($sformatf("start_command got %02h want %02h",
                                got.start_command, want.start_command));
    if (got.release_gyro_select !== want.release_gyro_select)
      report_mismatch($sformatf("release_gyro_select got %b want %b",
                                got.release_gyro_select, want.release_gyro_select));
    if (got.release_accel_select !== want.release_accel_select)
      report_mismatch($sformatf("release_accel_select got %b want %b",
                                got.release_accel_select, want.release_accel_select));
    if (got.raise_notify !== want.raise_notify)
      report_mismatch($sformatf("raise_notify got %b want %b",
                                got.raise_notify, want.raise_notify));
    if (got.gyro_sample_taken !== want.gyro_sample_taken)
      report_mismatch($sformatf("gyro_sample_taken got %b want %b",
                                got.gyro_sample_taken, want.gyro_sample_taken));
    if (got.accel_sample_taken !== want.accel_sample_taken)
      report_mismatch($sformatf("accel_sample_taken got %b want %b",
                                got.accel_sample_taken, want.accel_sample_taken));
    if (got.temp_sample_taken !== want.temp_sample_taken)
      report_mismatch($sformatf("temp_sample_taken got %b want %b",
                                got.temp_sample_taken, want.temp_sample_taken));
  endtask

  // input driver: new transaction only once the previous one was taken
  always @(negedge clk) begin
    if (!in_valid || last_in_fire) begin
      if (event_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_data  <= event_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    // result side backpressure
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // monitor: predict on input transactions, check result transactions
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      last_in_fire <= 1'b0;
    end else begin
      last_in_fire <= in_valid && !in_stall;
      // results here come from earlier transactions, so check before predicting
      if (out_valid && !out_stall) begin
        if (want_results.size() == 0)
          report_mismatch("result transaction with nothing expected");
        else
          check_result(out_data, want_results.pop_front());
      end
      if (in_valid && !in_stall) begin
        want_results.push_back(next_schedule(in_data));
        accepted_count <= accepted_count + 1;
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("imu_spi_read_scheduler test failed");
      $finish;
    end
  end

  task automatic queue_event(input logic [1:0] kind, input logic busy);
    in_item_t e;
    e.kind     = kind;
    e.bus_busy = busy;
    event_queue.push_back(e);
    queued_count++;
  endtask

  // every queued transaction taken and every result back
  task automatic wait_drained();
    while (accepted_count != queued_count || want_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // only written while the block is drained
  task automatic write_start_enable(input logic value);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    en_copy = value;
  endtask

  // mostly complete read cycles (ready, completions, poll) with random
  // content, the rest loose events
  task automatic queue_random_traffic(input int count);
    int first;
    first = queued_count;
    while (queued_count - first < count) begin
      if ($urandom_range(0, 99) < 70) begin
        queue_event(2'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0)
          queue_event(2'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 3)) queue_event(KIND_XFER_DONE, $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) != 0)
          queue_event(KIND_POLL, 1'($urandom_range(0, 1)));
      end else begin
        queue_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_write_data = 1'b0;
    rst_n          = 1'b0;
    queued_count   = 0;
    accepted_count = 0;
    cycle_count    = 0;
    errors         = 0;
    idle_pct       = 31;
    stall_pct      = 31;
    gyro_st        = '0;
    accel_st       = '0;
    temp_st        = '0;
    en_copy        = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // starts disabled: only completions may launch reads
    write_start_enable(1'b0);
    queue_event(KIND_POLL, 1'b0);        // poll with nothing done
    queue_event(KIND_XFER_DONE, 1'b0);   // completion with nothing in flight
    queue_event(KIND_ACCEL_RDY, 1'b0);   // pending only while disabled
    queue_event(KIND_GYRO_RDY, 1'b0);
    queue_event(KIND_XFER_DONE, 1'b1);   // bus busy blocks the start
    queue_event(KIND_XFER_DONE, 1'b0);   // completion launches gyro first
    queue_event(KIND_XFER_DONE, 1'b0);   // gyro release, accel start, notify
    queue_event(KIND_XFER_DONE, 1'b0);   // accel release, temperature start
    queue_event(KIND_POLL, 1'b1);
    queue_event(KIND_XFER_DONE, 1'b0);
    queue_event(KIND_POLL, 1'b0);
    wait_drained();

    // enabled: data-ready events launch directly
    write_start_enable(1'b1);
    queue_event(KIND_GYRO_RDY, 1'b1);    // busy, stays pending
    queue_event(KIND_GYRO_RDY, 1'b0);
    queue_event(KIND_GYRO_RDY, 1'b0);    // own in-flight flag does not block
    queue_event(KIND_ACCEL_RDY, 1'b0);   // gyro in flight blocks accel
    queue_event(KIND_XFER_DONE, 1'b0);
    queue_event(KIND_ACCEL_RDY, 1'b0);   // accel restarts over its own flight
    queue_event(KIND_XFER_DONE, 1'b0);
    queue_event(KIND_POLL, 1'b0);
    queue_event(KIND_XFER_DONE, 1'b1);
    queue_event(KIND_POLL, 1'b1);
    queue_event(KIND_POLL, 1'b0);
    wait_drained();

    queue_random_traffic(300);
    wait_drained();

    write_start_enable(1'b0);
    queue_random_traffic(150);
    wait_drained();

    // back-to-back stretch, no gaps on either side
    write_start_enable(1'b1);
    idle_pct  = 0;
    stall_pct = 0;
    queue_random_traffic(300);
    wait_drained();

    write_start_enable(1'b0);
    idle_pct  = 31;
    stall_pct = 31;
    queue_random_traffic(100);
    wait_drained();

    if (want_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", want_results.size()));
    if (errors == 0)
      $display("imu_spi_read_scheduler test passed");
    else
      $display("imu_spi_read_scheduler test failed");
    $finish;
  end

endmodule
